// ===== src/ppba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ppba_pkg;

  localparam int MAX_REGIONS_DEF = 8;
  localparam int PAGE_SHIFT_DEF  = 12;

  // Input command codes.
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_ALLOC = 2'd2,
    OP_NONE  = 2'd3
  } ppba_op_t;

  // Result status codes.
  typedef enum logic [2:0] {
    STS_OK      = 3'd0,
    STS_NO_PAGE = 3'd1,
    STS_SKIPPED = 3'd2,
    STS_FULL    = 3'd3,
    STS_CLEARED = 3'd4
  } ppba_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_EXEC,
    S_READ,
    S_CHECK,
    S_OUT
  } ppba_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_in;
    logic prep;
    logic exec;
    logic hit;
    logic step;
    logic load_out;
  } ppba_ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_alloc;
    logic table_empty;
    logic fits;
    logic last;
    logic out_free;
  } ppba_sts_t;

endpackage

`default_nettype wire

// ===== src/ppba_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ppba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/ppba_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ppba_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ppba_pkg::ppba_sts_t sts,
  output ppba_pkg::ppba_ctl_t     ctl
);

  ppba_pkg::ppba_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ppba_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ppba_pkg::S_IDLE: begin
        if (in_valid) state_nxt = ppba_pkg::S_PREP;
      end
      ppba_pkg::S_PREP: state_nxt = ppba_pkg::S_EXEC;
      ppba_pkg::S_EXEC: begin
        if (sts.is_alloc && !sts.table_empty) state_nxt = ppba_pkg::S_READ;
        else state_nxt = ppba_pkg::S_OUT;
      end
      ppba_pkg::S_READ: state_nxt = ppba_pkg::S_CHECK;
      ppba_pkg::S_CHECK: begin
        if (sts.fits || sts.last) state_nxt = ppba_pkg::S_OUT;
        else state_nxt = ppba_pkg::S_READ;
      end
      ppba_pkg::S_OUT: begin
        if (sts.out_free) state_nxt = ppba_pkg::S_IDLE;
      end
      default: state_nxt = ppba_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    case (state_r)
      ppba_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        ctl.load_in = in_valid;
      end
      ppba_pkg::S_PREP:  ctl.prep = 1'b1;
      ppba_pkg::S_EXEC:  ctl.exec = 1'b1;
      ppba_pkg::S_READ:  ctl = '0;
      ppba_pkg::S_CHECK: begin
        ctl.hit  = sts.fits;
        ctl.step = !sts.fits && !sts.last;
      end
      ppba_pkg::S_OUT:   ctl.load_out = sts.out_free;
      default:           ctl = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/ppba_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ppba_dp #(
  parameter int MAX_REGIONS = ppba_pkg::MAX_REGIONS_DEF,
  parameter int PAGE_SHIFT  = ppba_pkg::PAGE_SHIFT_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ppba_pkg::ppba_ctl_t ctl,
  output ppba_pkg::ppba_sts_t      sts,
  input  wire logic [1:0]          in_command,
  input  wire logic [63:0]         in_region_base,
  input  wire logic [63:0]         in_region_size,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [2:0]               out_status,
  output logic [63:0]              out_page_address,
  output logic [63:0]              out_total_bytes,
  output logic [63:0]              out_avail_bytes
);

  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam logic [63:0] PG_SIZE = 64'd1 << PAGE_SHIFT;
  localparam logic [63:0] PG_MASK = PG_SIZE - 64'd1;
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_REGIONS);

  ppba_pkg::ppba_op_t     cmd_r;
  ppba_pkg::ppba_status_t status_r;
  logic [63:0] lo_r, hi_r, span_r, addr_r;
  logic        small_r, empty_r;
  logic [CW-1:0] count_r;
  logic [IW-1:0] idx_r;
  logic [63:0] total_r, free_r;
  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [63:0] out_addr_r, out_total_r, out_free_r;

  logic [63:0] end_rd, next_rd, next_sum;
  logic        add_ok, end_we, next_we;
  logic [IW-1:0] waddr;
  logic [63:0] next_wdata;

  // An add is stored only when the table has room and the rounded range holds a page.
  assign add_ok = (cmd_r == ppba_pkg::OP_ADD) && (count_r != COUNT_MAX) &&
                  !small_r && !empty_r;

  // The page fits when next + page does not pass the end, with 64-bit wrap as given.
  assign next_sum = next_rd + PG_SIZE;

  assign end_we     = ctl.exec && add_ok;
  assign next_we    = end_we || ctl.hit;
  assign waddr      = ctl.hit ? idx_r : count_r[IW-1:0];
  assign next_wdata = ctl.hit ? next_sum : lo_r;

  ppba_ram #(.WIDTH(64), .DEPTH(MAX_REGIONS), .AW(IW)) u_end_ram (
    .clk   (clk),
    .we    (end_we),
    .waddr (waddr),
    .wdata (hi_r),
    .raddr (idx_r),
    .rdata (end_rd)
  );

  ppba_ram #(.WIDTH(64), .DEPTH(MAX_REGIONS), .AW(IW)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (waddr),
    .wdata (next_wdata),
    .raddr (idx_r),
    .rdata (next_rd)
  );

  assign sts.is_alloc    = (cmd_r == ppba_pkg::OP_ALLOC);
  assign sts.table_empty = (count_r == '0);
  assign sts.fits        = !(next_sum > end_rd);
  assign sts.last        = ((CW'(idx_r) + CW'(1)) == count_r);
  assign sts.out_free    = !out_valid_r || out_ready;

  // Control state: table fill, running byte counts and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      total_r     <= '0;
      free_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.exec) begin
        if (cmd_r == ppba_pkg::OP_CLEAR) begin
          count_r <= '0;
          total_r <= '0;
          free_r  <= '0;
        end else if (add_ok) begin
          count_r <= count_r + CW'(1);
          total_r <= total_r + span_r;
          free_r  <= free_r + span_r;
        end
      end
      if (ctl.hit) begin
        free_r <= free_r - PG_SIZE;
      end
      if (ctl.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      cmd_r   <= ppba_pkg::ppba_op_t'(in_command);
      lo_r    <= (in_region_base + PG_MASK) & ~PG_MASK;
      hi_r    <= (in_region_base + in_region_size) & ~PG_MASK;
      small_r <= (in_region_size < PG_SIZE);
      addr_r  <= '0;
    end
    if (ctl.prep) begin
      span_r  <= hi_r - lo_r;
      empty_r <= (hi_r <= lo_r);
    end
    if (ctl.exec) begin
      idx_r <= '0;
      case (cmd_r)
        ppba_pkg::OP_CLEAR: status_r <= ppba_pkg::STS_CLEARED;
        ppba_pkg::OP_ADD: begin
          if (count_r == COUNT_MAX) status_r <= ppba_pkg::STS_FULL;
          else if (small_r || empty_r) status_r <= ppba_pkg::STS_SKIPPED;
          else status_r <= ppba_pkg::STS_OK;
        end
        ppba_pkg::OP_ALLOC: status_r <= ppba_pkg::STS_NO_PAGE;
        ppba_pkg::OP_NONE:  status_r <= ppba_pkg::STS_OK;
        default:            status_r <= ppba_pkg::STS_OK;
      endcase
    end
    if (ctl.step) begin
      idx_r <= idx_r + IW'(1);
    end
    if (ctl.hit) begin
      addr_r   <= next_rd;
      status_r <= ppba_pkg::STS_OK;
    end
    if (ctl.load_out) begin
      out_status_r <= status_r;
      out_addr_r   <= addr_r;
      out_total_r  <= total_r;
      out_free_r   <= free_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_page_address = out_addr_r;
  assign out_total_bytes  = out_total_r;
  assign out_avail_bytes  = out_free_r;

endmodule

`default_nettype wire

// ===== src/physical_page_bump_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Beat contents
// in_*      input      in_valid / in_ready  command, region_base, region_size
// out_*     output     out_valid/out_ready  status, page_address, total_bytes, avail_bytes
//
// A clear, add or unused command passes through the accepting state, which captures
// the beat and rounds the range, range preparation, table update and output load,
// which waits until the output register is free.
// An allocate adds a read state and a check state for every table entry examined,
// since the scan reads the region table one entry at a time through its registered
// read port.
// Reset clears the region count, the byte counters and output valid; the table contents need none.
// A result waits in the output register while the next beat is already accepted
// and processed; that beat completes once the register is free.

module physical_page_bump_allocator #(
  parameter int MAX_REGIONS = ppba_pkg::MAX_REGIONS_DEF,
  parameter int PAGE_SHIFT  = ppba_pkg::PAGE_SHIFT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [63:0] in_region_base,
  input  wire logic [63:0] in_region_size,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [63:0]      out_page_address,
  output logic [63:0]      out_total_bytes,
  output logic [63:0]      out_avail_bytes
);

  // The controller sequences each beat; the datapath owns the region table
  // (two RAMs holding the page-aligned end and the next free page), the running
  // total and free byte counts, and the output register.
  ppba_pkg::ppba_ctl_t ctl;
  ppba_pkg::ppba_sts_t sts;

  ppba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  ppba_dp #(
    .MAX_REGIONS (MAX_REGIONS),
    .PAGE_SHIFT  (PAGE_SHIFT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .sts              (sts),
    .in_command       (in_command),
    .in_region_base   (in_region_base),
    .in_region_size   (in_region_size),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_page_address (out_page_address),
    .out_total_bytes  (out_total_bytes),
    .out_avail_bytes  (out_avail_bytes)
  );

endmodule

`default_nettype wire
